// ===== rtl/nfns_pkg.sv =====
package nfns_pkg;

  localparam int NFNS_MAX_NODES = 256;
  localparam int NFNS_FLAG_BITS = 16;

  localparam int COORD_W = 16;
  localparam int MAG_W   = COORD_W + 1;   // holds |diff| and the 99999 limit
  localparam int DIST_W  = 2 * MAG_W;

  localparam logic [MAG_W-1:0]  DEFAULT_LIMIT = 17'd99999;
  localparam logic [DIST_W-1:0] MAX_DIST_SQ   = 34'd9999800001;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Y    = 2'd1;
  localparam logic [1:0] AX_LAST = 2'd2;

  typedef struct packed {
    logic               op;
    logic [7:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               present;
    logic [15:0]        node_flags;
    logic [15:0]        max_distance;
    logic [15:0]        whitelist;
  } nfns_cmd_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  node_slot;
    logic [33:0] distance_squared;
  } nfns_res_t;

  // tags travelling with each operand through the distance unit
  typedef struct packed {
    logic valid;
    logic lim;    // operand is the distance limit, result seeds best
    logic first;  // first axis of a slot
    logic last;   // last axis of a slot
    logic ok;     // slot present and passes the whitelist
    logic fin;    // last axis of the last slot
  } nfns_tag_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
  } nfns_stat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LIM,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } nfns_state_t;

endpackage

// ===== rtl/nfns_ram.sv =====
module nfns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/nfns_dist.sv =====
module nfns_dist #(
  parameter int MAX_NODES = nfns_pkg::NFNS_MAX_NODES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nfns_pkg::nfns_tag_t                 a_tag,
  input  logic [nfns_pkg::MAG_W-1:0]          a_mag,
  input  logic [$clog2(MAX_NODES)-1:0]        a_slot,
  output logic [nfns_pkg::DIST_W-1:0]         best_dist,
  output logic [$clog2(MAX_NODES)-1:0]        best_slot,
  output nfns_pkg::nfns_stat_t                stat
);

  localparam int AW = $clog2(MAX_NODES);

  nfns_pkg::nfns_tag_t              b_tag;
  logic [nfns_pkg::DIST_W-1:0]      b_sq;
  logic [AW-1:0]                    b_slot;
  logic [nfns_pkg::DIST_W-1:0]      sq_full;
  logic [nfns_pkg::DIST_W-1:0]      acc;
  logic [nfns_pkg::DIST_W-1:0]      sum;
  logic                             better;
  logic                             hit;
  logic                             scan_end;

  // the one squarer, shared by the limit and every axis of every slot
  assign sq_full = a_mag * a_mag;

  assign sum    = (b_tag.first ? '0 : acc) + b_sq;
  assign better = b_tag.last && b_tag.ok && (sum < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag    <= '0;
      hit      <= 1'b0;
      scan_end <= 1'b0;
    end else begin
      b_tag    <= a_tag;
      scan_end <= b_tag.valid && b_tag.fin;
      if (b_tag.valid) begin
        if (b_tag.lim) begin
          hit <= 1'b0;
        end else if (better) begin
          hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    b_sq   <= sq_full;
    b_slot <= a_slot;
    if (b_tag.valid) begin
      if (b_tag.lim) begin
        best_dist <= b_sq;
      end else begin
        acc <= sum;
        if (better) begin
          best_dist <= sum;
          best_slot <= b_slot;
        end
      end
    end
  end

  assign stat.hit      = hit;
  assign stat.scan_end = scan_end;

  a_lim_clears_hit: assert property (@(posedge clk) disable iff (rst)
    (b_tag.valid && b_tag.lim) |=> !hit)
    else $error("hit not cleared by limit load");

endmodule

// ===== rtl/nearest_flagged_node_search_unit.sv =====
// Write item: result valid the cycle after accept; one write per cycle while the output drains.
// Query item: the result follows the limit load, the scan of every slot and the drain; next item
// taken once idle again; one squarer does one axis per cycle, three axes per slot.
// Reset (rst, synchronous): a clearing pass over all MAX_NODES slots marks every slot absent;
// no item is accepted until it ends.
module nearest_flagged_node_search_unit #(
  parameter int MAX_NODES = nfns_pkg::NFNS_MAX_NODES,
  parameter int FLAG_BITS = nfns_pkg::NFNS_FLAG_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  nfns_pkg::nfns_cmd_t cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output nfns_pkg::nfns_res_t res
);

  localparam int AW     = $clog2(MAX_NODES);
  localparam int CW     = nfns_pkg::COORD_W;
  localparam int WORD_W = 1 + FLAG_BITS + 3 * CW;
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_NODES - 1);

  nfns_pkg::nfns_state_t state, state_next;
  logic [AW-1:0] clr_idx, clr_idx_next;
  logic [AW-1:0] cur_idx, cur_idx_next;
  logic [1:0]    ax, ax_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  logic accept, w_accept, q_accept, slot_ok, out_free, load_query;

  logic signed [CW-1:0]         qx, qy, qz;
  logic [nfns_pkg::MAG_W-1:0]   q_lim;
  logic [FLAG_BITS-1:0]         q_wl;

  logic                         n_present;
  logic [FLAG_BITS-1:0]         n_flags;
  logic signed [CW-1:0]         n_c, q_c;
  logic signed [CW:0]           diff;
  logic [nfns_pkg::MAG_W-1:0]   mag;
  logic                         n_ok;

  nfns_pkg::nfns_tag_t          a_tag, a_tag_next;
  logic [nfns_pkg::MAG_W-1:0]   a_mag, a_mag_next;
  logic [AW-1:0]                a_slot;

  logic [nfns_pkg::DIST_W-1:0]  best_dist;
  logic [AW-1:0]                best_slot;
  nfns_pkg::nfns_stat_t         stat;

  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = (state != nfns_pkg::S_IDLE) || (cmd.op == nfns_pkg::OP_WRITE && !out_free);
  assign accept    = cmd_valid && !cmd_stall;
  assign w_accept  = accept && (cmd.op == nfns_pkg::OP_WRITE);
  assign q_accept  = accept && (cmd.op == nfns_pkg::OP_QUERY);
  assign slot_ok   = 32'(cmd.slot) < MAX_NODES;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= nfns_pkg::S_CLEAR;
      clr_idx <= '0;
      cur_idx <= '0;
      ax      <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      cur_idx <= cur_idx_next;
      ax      <= ax_next;
    end
  end

  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    cur_idx_next = cur_idx;
    ax_next      = ax;
    wr_en        = 1'b0;
    wr_addr      = clr_idx;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = cur_idx;
    load_query   = 1'b0;
    unique case (state)
      nfns_pkg::S_CLEAR: begin
        wr_en        = 1'b1;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == LAST_SLOT) begin
          state_next = nfns_pkg::S_IDLE;
        end
      end
      nfns_pkg::S_IDLE: begin
        // removal writes the word too; the point is never used while absent
        if (w_accept && slot_ok) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cmd.slot);
          wr_data = {cmd.present, FLAG_BITS'(cmd.node_flags), cmd.pos_x, cmd.pos_y, cmd.pos_z};
        end
        if (q_accept) begin
          rd_en        = 1'b1;
          rd_addr      = '0;
          cur_idx_next = '0;
          ax_next      = '0;
          state_next   = nfns_pkg::S_LIM;
        end
      end
      nfns_pkg::S_LIM: begin
        state_next = nfns_pkg::S_SCAN;
      end
      nfns_pkg::S_SCAN: begin
        if (ax == nfns_pkg::AX_LAST) begin
          ax_next = '0;
          if (cur_idx == LAST_SLOT) begin
            state_next = nfns_pkg::S_DRAIN;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = cur_idx + 1'b1;
            cur_idx_next = cur_idx + 1'b1;
          end
        end else begin
          ax_next = ax + 1'b1;
        end
      end
      nfns_pkg::S_DRAIN: begin
        if (stat.scan_end) begin
          state_next = nfns_pkg::S_DONE;
        end
      end
      nfns_pkg::S_DONE: begin
        if (out_free) begin
          load_query = 1'b1;
          state_next = nfns_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = nfns_pkg::S_CLEAR;
      end
    endcase
  end

  nfns_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (q_accept) begin
      qx    <= cmd.pos_x;
      qy    <= cmd.pos_y;
      qz    <= cmd.pos_z;
      q_lim <= (cmd.max_distance != '0) ? {1'b0, cmd.max_distance} : nfns_pkg::DEFAULT_LIMIT;
      q_wl  <= FLAG_BITS'(cmd.whitelist);
    end
  end

  // operand select: read word stays put for the three axes of a slot
  assign n_present = rd_data[WORD_W-1];
  assign n_flags   = rd_data[WORD_W-2 -: FLAG_BITS];
  assign n_ok      = n_present && ((q_wl == '0) || ((n_flags & q_wl) != '0));

  always_comb begin
    unique case (ax)
      nfns_pkg::AX_X: begin
        n_c = rd_data[3*CW-1 -: CW];
        q_c = qx;
      end
      nfns_pkg::AX_Y: begin
        n_c = rd_data[2*CW-1 -: CW];
        q_c = qy;
      end
      default: begin
        n_c = rd_data[CW-1:0];
        q_c = qz;
      end
    endcase
  end

  assign diff = {n_c[CW-1], n_c} - {q_c[CW-1], q_c};
  assign mag  = diff[CW] ? nfns_pkg::MAG_W'(-diff) : nfns_pkg::MAG_W'(diff);

  always_comb begin
    a_tag_next = '0;
    a_mag_next = mag;
    if (state == nfns_pkg::S_LIM) begin
      a_tag_next.valid = 1'b1;
      a_tag_next.lim   = 1'b1;
      a_mag_next       = q_lim;
    end else if (state == nfns_pkg::S_SCAN) begin
      a_tag_next.valid = 1'b1;
      a_tag_next.first = (ax == nfns_pkg::AX_X);
      a_tag_next.last  = (ax == nfns_pkg::AX_LAST);
      a_tag_next.ok    = n_ok;
      a_tag_next.fin   = (ax == nfns_pkg::AX_LAST) && (cur_idx == LAST_SLOT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
    end else begin
      a_tag <= a_tag_next;
    end
  end

  always_ff @(posedge clk) begin
    a_mag  <= a_mag_next;
    a_slot <= cur_idx;
  end

  nfns_dist #(
    .MAX_NODES (MAX_NODES)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .a_tag     (a_tag),
    .a_mag     (a_mag),
    .a_slot    (a_slot),
    .best_dist (best_dist),
    .best_slot (best_slot),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (w_accept || load_query) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (w_accept) begin
      res <= '0;
    end else if (load_query) begin
      res.found            <= stat.hit;
      res.node_slot        <= stat.hit ? 8'(best_slot) : '0;
      res.distance_squared <= stat.hit ? best_dist : '0;
    end
  end

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    w_accept |=> (res_valid && !res.found))
    else $error("write item gave no empty result");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.found) |-> (res.distance_squared < nfns_pkg::MAX_DIST_SQ))
    else $error("found distance not below the largest limit");

  a_scan_end_drain: assert property (@(posedge clk) disable iff (rst)
    stat.scan_end |-> (state == nfns_pkg::S_DRAIN))
    else $error("scan end outside drain");

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    q_accept |=> (state == nfns_pkg::S_LIM))
    else $error("query accepted without starting a scan");

endmodule
